>>> hdl/lcal_pkg.sv
// Shared widths, function codes and status codes for the LCA lifting engine.
`default_nettype none
package lcal_pkg;
	localparam int NODE_W  = 11;
	localparam int DEPTH_W = 10;
	localparam logic [DEPTH_W-1:0] DEPTH_MAX = 10'd1023;

	typedef enum logic [1:0] {
		FN_LOAD  = 2'd0,
		FN_BUILD = 2'd1,
		FN_QUERY = 2'd2,
		FN_CLEAR = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_RANGE  = 2'd1,
		STAT_NONE   = 2'd2,
		STAT_UNUSED = 2'd3
	} status_t;
endpackage
`default_nettype wire

>>> hdl/lowest_common_ancestor_lifting_unit.sv
// Lowest common ancestor engine: binary lifting over an ancestor memory with one read and one write port.
// A load is written in idle; a range error goes straight to the output state; a query
// lifts the deeper node over S = min(LIFT_LEVELS, 10) levels and then climbs both nodes.
// Build fills levels 1..LIFT_LEVELS-1 of the table, then computes the depth of each node.
// One word at a time; not ready while an item is in work.
// Reset and clear sweep all LIFT_LEVELS * 2**clog2(MAX_NODES+1) words of the memory.
`default_nettype none
module lowest_common_ancestor_lifting_unit #(
	parameter int MAX_NODES   = 1024,
	parameter int LIFT_LEVELS = 11
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_wr_en,
	input  wire logic [lcal_pkg::NODE_W-1:0] cfg_wr_data,   // node_count
	input  wire logic                      s_axis_tvalid,
	output logic                           s_axis_tready,
	input  wire logic [23:0]               s_axis_tdata,    // node_a[10:0], node_b[21:11]
	input  wire logic [1:0]                s_axis_tuser,    // func[1:0]
	output logic                           m_axis_tvalid,
	input  wire logic                      m_axis_tready,
	output logic [15:0]                    m_axis_tdata,    // common_node[10:0]
	output logic [1:0]                     m_axis_tuser     // status[1:0]
);
	import lcal_pkg::*;

	localparam int NW   = $clog2(MAX_NODES + 1);
	localparam int LVW  = (LIFT_LEVELS < 2) ? 1 : $clog2(LIFT_LEVELS);
	localparam int AW   = (NW > NODE_W) ? NW : NODE_W;
	localparam int LIFT_STEPS = (LIFT_LEVELS < 10) ? LIFT_LEVELS : 10;
	localparam int ANC_DEPTH  = LIFT_LEVELS * (2 ** NW);
	localparam logic [LVW-1:0] LVL_TOP  = LVW'(LIFT_LEVELS - 1);
	localparam logic [LVW-1:0] LVL_LAST = LVW'(LIFT_STEPS - 1);
	localparam logic [NW-1:0]  V_MAX    = NW'(MAX_NODES);

	typedef enum logic [17:0] {
		ST_IDLE = 18'h00001,
		ST_CLR  = 18'h00002,
		ST_BT1  = 18'h00004,
		ST_BT2  = 18'h00008,
		ST_BT3  = 18'h00010,
		ST_BD1  = 18'h00020,
		ST_BD2  = 18'h00040,
		ST_BDW  = 18'h00080,
		ST_QD1  = 18'h00100,
		ST_QD2  = 18'h00200,
		ST_QD3  = 18'h00400,
		ST_QL1  = 18'h00800,
		ST_QL2  = 18'h01000,
		ST_QCHK = 18'h02000,
		ST_QC1  = 18'h04000,
		ST_QC2  = 18'h08000,
		ST_QC3  = 18'h10000,
		ST_QOUT = 18'h20000
	} state_t;

	state_t state_q;

	logic [NODE_W-1:0]  node_count_q;
	logic [NODE_W-1:0]  n_cap;
	logic [LVW-1:0]     k_q;
	logic [NW-1:0]      bv_q;
	logic [AW-1:0]      cur_q;
	logic [LIFT_LEVELS-1:0] d_q;
	logic [NODE_W-1:0]  a_q, b_q, ua_q;
	logic [DEPTH_W-1:0] da_q, diff_q;
	logic               final_q;
	logic [NODE_W-1:0]  res_node_q;
	status_t            res_stat_q;

	logic [NODE_W-1:0]  anc_mem [ANC_DEPTH];
	logic [DEPTH_W-1:0] dep_mem [2**NW];
	logic [NODE_W-1:0]  anc_rd_q;
	logic               oob_q;
	logic [DEPTH_W-1:0] dep_rd_q;

	logic [LVW-1:0]     rd_lvl;
	logic [AW-1:0]      rd_node;
	logic               anc_we;
	logic [LVW-1:0]     wr_lvl;
	logic [NW-1:0]      wr_node;
	logic [NODE_W-1:0]  wr_data;
	logic               dep_we;
	logic [NW-1:0]      dep_waddr;
	logic [DEPTH_W-1:0] dep_wdata;
	logic [NW-1:0]      dep_raddr;
	logic [NODE_W-1:0]  lk_data;
	logic [NODE_W-1:0]  in_a, in_b;
	func_t              in_func;
	logic               in_acc;
	logic [DEPTH_W-1:0] d_sat;

	assign in_a    = s_axis_tdata[10:0];
	assign in_b    = s_axis_tdata[21:11];
	assign in_func = func_t'(s_axis_tuser);
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign n_cap   = (32'(node_count_q) > MAX_NODES) ? NODE_W'(MAX_NODES) : node_count_q;
	// a lookup of a node beyond the table yields none
	assign lk_data = oob_q ? '0 : anc_rd_q;
	assign d_sat   = (32'(d_q) > 32'(DEPTH_MAX)) ? DEPTH_MAX : DEPTH_W'(d_q);

	always_comb begin
		rd_lvl  = '0;
		rd_node = '0;
		unique case (state_q)
			ST_BT1: begin
				rd_lvl  = k_q - 1'b1;
				rd_node = AW'(bv_q);
			end
			ST_BT2: begin
				rd_lvl  = k_q - 1'b1;
				rd_node = AW'(lk_data);
			end
			ST_BD1: begin
				rd_lvl  = k_q;
				rd_node = cur_q;
			end
			ST_QL1, ST_QC1: begin
				rd_lvl  = k_q;
				rd_node = AW'(a_q);
			end
			ST_QC2: begin
				rd_lvl  = k_q;
				rd_node = AW'(b_q);
			end
			default: begin
				rd_lvl  = '0;
				rd_node = '0;
			end
		endcase
	end

	always_comb begin
		anc_we  = 1'b0;
		wr_lvl  = '0;
		wr_node = '0;
		wr_data = '0;
		dep_we  = 1'b0;
		dep_waddr = bv_q;
		dep_wdata = '0;
		if (state_q == ST_CLR) begin
			anc_we  = 1'b1;
			wr_lvl  = k_q;
			wr_node = bv_q;
			dep_we  = (k_q == '0);
		end else if (state_q == ST_BT3) begin
			anc_we  = 1'b1;
			wr_lvl  = k_q;
			wr_node = bv_q;
			wr_data = lk_data;
		end else if (state_q == ST_BDW) begin
			dep_we    = 1'b1;
			dep_wdata = d_sat;
		end else if (in_acc && in_func == FN_LOAD && in_a != '0 && in_a <= n_cap
				&& in_b <= n_cap) begin
			anc_we  = 1'b1;
			wr_node = NW'(in_a);
			wr_data = in_b;
		end
	end

	assign dep_raddr = (state_q == ST_QD1) ? NW'(a_q) : NW'(b_q);

	always_ff @(posedge clk) begin
		if (anc_we) begin
			anc_mem[{wr_lvl, wr_node}] <= wr_data;
		end
		anc_rd_q <= anc_mem[{rd_lvl, rd_node[NW-1:0]}];
		oob_q    <= (rd_node > AW'(MAX_NODES));
		if (dep_we) begin
			dep_mem[dep_waddr] <= dep_wdata;
		end
		dep_rd_q <= dep_mem[dep_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_W'(1);
		end else if (cfg_wr_en) begin
			node_count_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLR;
			k_q           <= '0;
			bv_q          <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready && state_q != ST_QOUT) begin
				m_axis_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						a_q <= in_a;
						b_q <= in_b;
						unique case (in_func)
							FN_LOAD: state_q <= ST_IDLE;
							FN_BUILD: begin
								bv_q <= NW'(1);
								if (LIFT_LEVELS > 1) begin
									k_q     <= LVW'(1);
									state_q <= ST_BT1;
								end else begin
									k_q     <= LVL_TOP;
									cur_q   <= AW'(1);
									d_q     <= '0;
									state_q <= ST_BD1;
								end
							end
							FN_QUERY: begin
								if (in_a == '0 || in_a > n_cap || in_b == '0 || in_b > n_cap)
										begin
									res_node_q <= '0;
									res_stat_q <= STAT_RANGE;
									state_q    <= ST_QOUT;
								end else begin
									state_q <= ST_QD1;
								end
							end
							FN_CLEAR: begin
								k_q     <= '0;
								bv_q    <= '0;
								state_q <= ST_CLR;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_CLR: begin
					bv_q <= bv_q + 1'b1;
					if (bv_q == '1) begin
						if (k_q == LVL_TOP) begin
							state_q <= ST_IDLE;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end
				ST_BT1: state_q <= ST_BT2;
				ST_BT2: state_q <= ST_BT3;
				ST_BT3: begin
					if (bv_q == V_MAX) begin
						bv_q <= NW'(1);
						if (k_q == LVL_TOP) begin
							// tables done; start depth pass at node 1
							k_q     <= LVL_TOP;
							cur_q   <= AW'(1);
							d_q     <= '0;
							state_q <= ST_BD1;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= ST_BT1;
						end
					end else begin
						bv_q    <= bv_q + 1'b1;
						state_q <= ST_BT1;
					end
				end
				ST_BD1: state_q <= ST_BD2;
				ST_BD2: begin
					if (lk_data != '0) begin
						cur_q    <= AW'(lk_data);
						d_q[k_q] <= 1'b1;
					end
					if (k_q == '0) begin
						state_q <= ST_BDW;
					end else begin
						k_q     <= k_q - 1'b1;
						state_q <= ST_BD1;
					end
				end
				ST_BDW: begin
					if (bv_q == V_MAX) begin
						state_q <= ST_IDLE;
					end else begin
						bv_q    <= bv_q + 1'b1;
						cur_q   <= AW'(bv_q + 1'b1);
						d_q     <= '0;
						k_q     <= LVL_TOP;
						state_q <= ST_BD1;
					end
				end
				ST_QD1: state_q <= ST_QD2;
				ST_QD2: begin
					da_q    <= dep_rd_q;
					state_q <= ST_QD3;
				end
				ST_QD3: begin
					// keep the deeper node in a
					if (da_q < dep_rd_q) begin
						a_q    <= b_q;
						b_q    <= a_q;
						diff_q <= dep_rd_q - da_q;
					end else begin
						diff_q <= da_q - dep_rd_q;
					end
					k_q     <= '0;
					state_q <= ST_QL1;
				end
				ST_QL1: begin
					if (diff_q[k_q]) begin
						state_q <= ST_QL2;
					end else if (k_q == LVL_LAST) begin
						state_q <= ST_QCHK;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_QL2: begin
					a_q <= lk_data;
					if (k_q == LVL_LAST) begin
						state_q <= ST_QCHK;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= ST_QL1;
					end
				end
				ST_QCHK: begin
					if (a_q == b_q) begin
						res_node_q <= a_q;
						res_stat_q <= (a_q == '0) ? STAT_NONE : STAT_OK;
						state_q    <= ST_QOUT;
					end else begin
						k_q     <= LVL_TOP;
						final_q <= 1'b0;
						state_q <= ST_QC1;
					end
				end
				ST_QC1: state_q <= ST_QC2;
				ST_QC2: begin
					ua_q    <= lk_data;
					state_q <= ST_QC3;
				end
				ST_QC3: begin
					if (final_q) begin
						res_node_q <= (ua_q == lk_data) ? ua_q : '0;
						res_stat_q <= (ua_q == lk_data && ua_q != '0) ? STAT_OK : STAT_NONE;
						state_q    <= ST_QOUT;
					end else begin
						if (ua_q != lk_data) begin
							a_q <= ua_q;
							b_q <= lk_data;
						end
						if (k_q == '0) begin
							final_q <= 1'b1;
						end else begin
							k_q <= k_q - 1'b1;
						end
						state_q <= ST_QC1;
					end
				end
				ST_QOUT: begin
					// hold until the output register is free
					if (!m_axis_tvalid || m_axis_tready) begin
						m_axis_tvalid <= 1'b1;
						m_axis_tdata  <= {5'd0, res_node_q};
						m_axis_tuser  <= res_stat_q;
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_out_from_qout: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == ST_QOUT))
		else $error("result raised outside the output state");

	a_ok_has_node: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == STAT_OK) |-> (m_axis_tdata[10:0] != '0))
		else $error("ok status with no common node");

	a_err_no_node: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser == STAT_RANGE || m_axis_tuser == STAT_NONE))
		|-> (m_axis_tdata[10:0] == '0))
		else $error("error status with a node");

	a_load_idle_only: assert property (@(posedge clk) disable iff (!arst_n)
		(anc_we && state_q == ST_IDLE) |-> (in_acc && in_func == FN_LOAD))
		else $error("ancestor write in idle without a load");
`endif
endmodule
`default_nettype wire

>>> tb/tb_lowest_common_ancestor_lifting_unit.sv
// Self-checking testbench for the binary-lifting lowest common ancestor unit.
`default_nettype none
module tb_lowest_common_ancestor_lifting_unit;
	import lcal_pkg::*;

	localparam int NODES  = 1024;
	localparam int LEVELS = 11;

	typedef struct {
		func_t            fn;
		logic [NODE_W-1:0] a;
		logic [NODE_W-1:0] b;
	} tree_op_t;

	typedef struct {
		logic [NODE_W-1:0] node;
		status_t           st;
	} lca_answer_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [NODE_W-1:0] cfg_wr_data;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [23:0] s_axis_tdata;   // node_a[10:0], node_b[21:11]
	logic [1:0] s_axis_tuser;    // func[1:0]
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [15:0] m_axis_tdata;   // common_node[10:0]
	logic [1:0] m_axis_tuser;    // status[1:0]

	lowest_common_ancestor_lifting_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	tree_op_t    op_q[$];
	lca_answer_t answer_q[$];
	int          mismatches = 0;
	int          rand_items = 0;

	// model of the unit's tables
	logic [NODE_W-1:0]  jump_tab[LEVELS][NODES+1];
	logic [DEPTH_W-1:0] depth_tab[NODES+1];
	int                 live_count = 1;

	function automatic int jump(int k, int v);
		if (v > NODES)
			return 0;
		return jump_tab[k][v];
	endfunction

	function automatic void wipe_tables();
		for (int k = 0; k < LEVELS; k++)
			for (int v = 0; v <= NODES; v++)
				jump_tab[k][v] = '0;
		for (int v = 0; v <= NODES; v++)
			depth_tab[v] = '0;
	endfunction

	function automatic void lift_build();
		int cur;
		int d;
		int up;
		for (int k = 1; k < LEVELS; k++)
			for (int v = 1; v <= NODES; v++)
				jump_tab[k][v] = NODE_W'(jump(k - 1, jump(k - 1, v)));
		for (int v = 1; v <= NODES; v++) begin
			cur = v;
			d = 0;
			for (int k = LEVELS - 1; k >= 0; k--) begin
				up = jump(k, cur);
				if (up != 0) begin
					cur = up;
					d += 1 << k;
				end
			end
			depth_tab[v] = (d > DEPTH_MAX) ? DEPTH_MAX : DEPTH_W'(d);
		end
	endfunction

	function automatic int shared_ancestor(int a, int b);
		int t;
		int diff;
		int ua;
		int ub;
		if (depth_tab[a] < depth_tab[b]) begin
			t = a;
			a = b;
			b = t;
		end
		diff = depth_tab[a] - depth_tab[b];
		for (int k = 0; k < LEVELS && k < 10; k++)
			if (diff[k])
				a = jump(k, a);
		if (a == b)
			return a;
		for (int k = LEVELS - 1; k >= 0; k--) begin
			ua = jump(k, a);
			ub = jump(k, b);
			if (ua != ub) begin
				a = ua;
				b = ub;
			end
		end
		if (jump(0, a) == jump(0, b))
			return jump(0, a);
		return 0;
	endfunction

	function automatic void apply_op(tree_op_t op);
		int n;
		int c;
		lca_answer_t ans;
		n = (live_count > NODES) ? NODES : live_count;
		case (op.fn)
			FN_LOAD: begin
				if (op.a >= 1 && op.a <= n && op.b <= n)
					jump_tab[0][op.a] = op.b;
			end
			FN_BUILD: lift_build();
			FN_CLEAR: wipe_tables();
			default: begin
				if (op.a < 1 || op.a > n || op.b < 1 || op.b > n) begin
					ans.node = '0;
					ans.st = STAT_RANGE;
				end else begin
					c = shared_ancestor(op.a, op.b);
					ans.node = NODE_W'(c);
					ans.st = (c == 0) ? STAT_NONE : STAT_OK;
				end
				answer_q = {answer_q, ans};
			end
		endcase
	endfunction

	function automatic void push_op(func_t fn, int a, int b);
		tree_op_t op;
		op.fn = fn;
		op.a = NODE_W'(a);
		op.b = NODE_W'(b);
		op_q = {op_q, op};
	endfunction

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// sender: one word at a time, random gaps, gap-free stretches
	int send_gap = 0;
	int sent = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (send_gap > 0) begin
				send_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (op_q.size() > 0) begin
				tree_op_t op;
				op = op_q.pop_front();
				s_axis_tdata <= {2'b00, op.b, op.a};
				s_axis_tuser <= op.fn;
				s_axis_tvalid <= 1'b1;
				sent++;
				send_gap = ((sent / 64) % 3 == 1) ? 0 : $urandom_range(0, 3);
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// predict on every accepted input word
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			tree_op_t op;
			op.fn = func_t'(s_axis_tuser);
			op.a = s_axis_tdata[10:0];
			op.b = s_axis_tdata[21:11];
			apply_op(op);
		end
	end

	// receiver: random stalls, one long hold-off to back up the input
	int recv_stall = 0;
	int received = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				received++;
				if (received == 40)
					recv_stall = 600;
				else
					recv_stall = ((received / 32) % 3 == 2) ? 0 : $urandom_range(0, 3);
			end
			if (recv_stall > 0) begin
				recv_stall--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			lca_answer_t want;
			if (answer_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: node %0d status %0d",
						m_axis_tdata[10:0], m_axis_tuser);
			end else begin
				want = answer_q.pop_front();
				if (m_axis_tdata !== {5'b0, want.node} || m_axis_tuser !== want.st) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected node %0d status %0d, got node %0d status %0d",
							want.node, want.st, m_axis_tdata, m_axis_tuser);
				end
			end
		end
	end

	// drain: every phase ends with a query, so an empty answer queue means idle
	task automatic drain();
		while (op_q.size() != 0 || s_axis_tvalid || answer_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_count(int v);
		drain();
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= NODE_W'(v);
		live_count = v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic random_phase(int m, bit chain);
		int cnt;
		int r;
		int p;
		int q;
		r = $urandom_range(0, 2);
		cnt = (r == 0) ? m : (r == 1) ? $urandom_range(m, NODES) : NODES;
		set_count(cnt);
		if ($urandom_range(0, 2) == 0) begin
			push_op(FN_CLEAR, $urandom_range(0, 2047), $urandom_range(0, 2047));
			rand_items++;
		end
		for (int v = 2; v <= m; v++) begin
			r = $urandom_range(0, 99);
			if (chain)
				p = (r < 95) ? v - 1 : $urandom_range(0, v - 1);
			else if (r < 70)
				p = $urandom_range(1, v - 1);
			else if (r < 80)
				p = 0;
			else if (r < 88)
				p = v - 1;
			else
				p = $urandom_range(0, m);
			if (r >= 96)
				push_op(FN_LOAD, $urandom_range(0, 2047), $urandom_range(0, 2047));
			else
				push_op(FN_LOAD, v, p);
			rand_items++;
		end
		if ($urandom_range(0, 1))
			push_op(FN_QUERY, $urandom_range(1, m), $urandom_range(1, m));
		push_op(FN_BUILD, $urandom_range(0, 2047), $urandom_range(0, 2047));
		q = m + m / 2;
		for (int i = 0; i < q; i++) begin
			r = $urandom_range(0, 99);
			if (r < 88)
				push_op(FN_QUERY, $urandom_range(1, m), $urandom_range(1, m));
			else if (r < 96)
				push_op(FN_QUERY, $urandom_range(0, 2047), $urandom_range(0, 2047));
			else
				push_op(FN_LOAD, $urandom_range(1, m), $urandom_range(0, m));
			rand_items++;
		end
		push_op(FN_QUERY, $urandom_range(1, m), $urandom_range(1, m));
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		wipe_tables();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// single node: self parent, out-of-range loads and queries
		set_count(1);
		push_op(FN_QUERY, 1, 1);
		push_op(FN_QUERY, 0, 1);
		push_op(FN_QUERY, 1, 2047);
		push_op(FN_LOAD, 1, 1);
		push_op(FN_LOAD, 2, 1);
		push_op(FN_BUILD, 0, 0);
		push_op(FN_QUERY, 1, 1);

		// full count: extremes, two trees, a cycle, stale tables, clear
		set_count(NODES);
		push_op(FN_LOAD, 1024, 0);
		push_op(FN_LOAD, 2, 1);
		push_op(FN_LOAD, 3, 2);
		push_op(FN_LOAD, 1023, 1024);
		push_op(FN_LOAD, 1025, 1);
		push_op(FN_LOAD, 5, 2047);
		push_op(FN_LOAD, 7, 8);
		push_op(FN_LOAD, 8, 7);
		push_op(FN_LOAD, 9, 9);
		push_op(FN_QUERY, 3, 2);
		push_op(FN_BUILD, 2047, 2047);
		push_op(FN_QUERY, 3, 2);
		push_op(FN_QUERY, 3, 1023);
		push_op(FN_QUERY, 1024, 1023);
		push_op(FN_QUERY, 7, 8);
		push_op(FN_QUERY, 9, 3);
		push_op(FN_QUERY, 1025, 2);
		push_op(FN_QUERY, 2, 0);
		push_op(FN_LOAD, 3, 1024);
		push_op(FN_QUERY, 3, 1023);
		push_op(FN_CLEAR, 0, 0);
		push_op(FN_QUERY, 3, 2);

		// shrink count: links above the new count stay in the tables
		set_count(4);
		push_op(FN_LOAD, 4, 3);
		push_op(FN_BUILD, 0, 0);
		push_op(FN_QUERY, 4, 2);
		push_op(FN_QUERY, 4, 5);

		random_phase(400, 1'b1);
		while (rand_items < 1600)
			random_phase($urandom_range(40, 150), 1'b0);

		drain();
		repeat (200) @(posedge clk);
		if (mismatches == 0 && answer_q.size() == 0)
			$display("tb_lowest_common_ancestor_lifting_unit passed");
		else
			$display("tb_lowest_common_ancestor_lifting_unit failed");
		$finish;
	end

	initial begin
		#40000000;
		$display("tb_lowest_common_ancestor_lifting_unit failed");
		$finish;
	end
endmodule
`default_nettype wire
